@@ design/bdlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the debounced button with long press.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 10;
    localparam int unsigned TICK_WIDTH      = 10;
    localparam int unsigned CFG_IDX_WIDTH   = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 10;

    localparam int unsigned RESET_LONG    = 300;
    localparam int unsigned RESET_PERIOD  = 100;
    localparam int unsigned RESET_TIMEOUT = 10;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRESSED_LEVEL = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_REPEAT_MODE   = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_TICKS    = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PERIOD_TICKS  = 2'd3;

    typedef struct packed {
        logic                  pressed_level;
        logic                  repeat_mode;
        logic [TICK_WIDTH-1:0] long_ticks;
        logic [TICK_WIDTH-1:0] period_ticks;
    } t_cfg;

    typedef struct packed {
        logic press_flag;
        logic long_flag;
        logic stable_pressed;
    } t_result;

endpackage

@@ design/bdlp_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module bdlp_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [bdlp_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output bdlp_pkg::t_cfg                       o_cfg
);

    bdlp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pressed_level <= 1'b0;
            r_cfg.repeat_mode   <= 1'b0;
            r_cfg.long_ticks    <= bdlp_pkg::TICK_WIDTH'(bdlp_pkg::RESET_LONG);
            r_cfg.period_ticks  <= bdlp_pkg::TICK_WIDTH'(bdlp_pkg::RESET_PERIOD);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdlp_pkg::CFG_PRESSED_LEVEL: r_cfg.pressed_level <= i_cfg_data[0];
                bdlp_pkg::CFG_REPEAT_MODE:   r_cfg.repeat_mode   <= i_cfg_data[0];
                bdlp_pkg::CFG_LONG_TICKS: begin
                    r_cfg.long_ticks <= i_cfg_data[bdlp_pkg::TICK_WIDTH-1:0];
                end
                bdlp_pkg::CFG_PERIOD_TICKS: begin
                    r_cfg.period_ticks <= i_cfg_data[bdlp_pkg::TICK_WIDTH-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/bdlp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_core
// Debounce history, hold and timeout counters and sticky event flags.
// ----------------------------------------------------------------------------
module bdlp_core #(
    parameter int unsigned COUNT_WIDTH = bdlp_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdlp_pkg::t_cfg    i_cfg,
    input  logic              i_accept,
    input  logic              i_pin_level,
    input  logic              i_ack_press,
    input  logic              i_ack_long,
    output bdlp_pkg::t_result o_result
);

    localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > bdlp_pkg::TICK_WIDTH) ?
                                        COUNT_WIDTH : bdlp_pkg::TICK_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] RESET_TMO = COUNT_WIDTH'(bdlp_pkg::RESET_TIMEOUT);
    localparam logic [COUNT_WIDTH-1:0] ONE       = COUNT_WIDTH'(1);

    logic [2:0]             r_hist,    n_hist;
    logic                   r_stable,  n_stable;
    logic [COUNT_WIDTH-1:0] r_hold,    n_hold;
    logic [COUNT_WIDTH-1:0] r_timeout, n_timeout;
    logic                   r_press,   n_press;
    logic                   r_long,    n_long;

    logic [CMP_WIDTH-1:0]   hold_ext;
    logic [CMP_WIDTH-1:0]   long_ext;
    logic [CMP_WIDTH-1:0]   period_ext;
    logic [COUNT_WIDTH-1:0] period_load;
    logic                   agree;
    logic                   at_pressed;
    logic                   tmo_fire;
    logic [COUNT_WIDTH-1:0] tmo_dec;

    assign hold_ext    = CMP_WIDTH'(r_hold);
    assign long_ext    = CMP_WIDTH'(i_cfg.long_ticks);
    assign period_ext  = CMP_WIDTH'(i_cfg.period_ticks);
    assign period_load = period_ext[COUNT_WIDTH-1:0];
    assign tmo_fire    = (r_timeout == ONE);
    assign tmo_dec     = (r_timeout == '0) ? r_timeout : r_timeout - ONE;

    always_comb begin
        n_hist     = {r_hist[1:0], i_pin_level};
        n_stable   = r_stable;
        n_hold     = r_hold;
        n_timeout  = r_timeout;
        n_press    = r_press & ~i_ack_press;
        n_long     = r_long & ~i_ack_long;
        agree      = (n_hist == 3'b000) || (n_hist == 3'b111);
        at_pressed = (r_stable == i_cfg.pressed_level);

        if (agree) begin
            if (n_hist[0] != r_stable) begin
                // debounced edge
                n_stable = n_hist[0];
                if (n_hist[0] == i_cfg.pressed_level) begin
                    n_press   = 1'b1;
                    n_timeout = period_load;
                end
            end else if (!i_cfg.repeat_mode) begin
                if (at_pressed) begin
                    if ((hold_ext < long_ext) && (r_hold != '1)) begin
                        n_hold = r_hold + ONE;
                    end else begin
                        n_press = 1'b0;
                        n_long  = 1'b1;
                    end
                end else begin
                    n_timeout = tmo_dec;
                    if (tmo_fire) begin
                        n_hold  = '0;
                        n_press = 1'b0;
                        n_long  = 1'b0;
                    end
                end
            end else begin
                n_timeout = tmo_dec;
                if (tmo_fire) begin
                    if (at_pressed) begin
                        n_press = 1'b1;
                    end
                    n_timeout = period_load;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist    <= 3'b111;
            r_stable  <= 1'b1;
            r_hold    <= '0;
            r_timeout <= RESET_TMO;
            r_press   <= 1'b0;
            r_long    <= 1'b0;
        end else if (i_accept) begin
            r_hist    <= n_hist;
            r_stable  <= n_stable;
            r_hold    <= n_hold;
            r_timeout <= n_timeout;
            r_press   <= n_press;
            r_long    <= n_long;
        end
    end

    assign o_result.press_flag     = n_press;
    assign o_result.long_flag      = n_long;
    assign o_result.stable_pressed = (n_stable == i_cfg.pressed_level);

endmodule

@@ design/button_debounce_long_press.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Three-sample button debounce with sticky press, long press and auto-repeat.
// ----------------------------------------------------------------------------
// Result is registered: valid in the cycle after the input transaction.
// Throughput: one transaction per cycle while o_ready is high; the state
// registers update in one pass; output frees in the same cycle it is taken.
// Reset: synchronous active-low; released level history, timeout of ten,
// flags and counters cleared, configuration to its defaults.
module button_debounce_long_press #(
    parameter int unsigned COUNT_WIDTH = bdlp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [bdlp_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_pin_level,
    input  logic                                i_ack_press,
    input  logic                                i_ack_long,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_press_flag,
    output logic                                o_long_flag,
    output logic                                o_stable_pressed
);

    bdlp_pkg::t_cfg    cfg;
    bdlp_pkg::t_result result;
    bdlp_pkg::t_result r_out;
    logic              r_out_valid;
    logic              accept;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    bdlp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bdlp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_pin_level (i_pin_level),
        .i_ack_press (i_ack_press),
        .i_ack_long  (i_ack_long),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_press_flag     = r_out.press_flag;
    assign o_long_flag      = r_out.long_flag;
    assign o_stable_pressed = r_out.stable_pressed;

endmodule

@@ sim/button_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_checker
// Watches the tick and result channels of the debounced button. It keeps its
// own copy of the debounce, hold and timeout state, works out the flags each
// accepted tick should give, and compares every accepted result with the
// oldest outstanding one. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module button_event_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [bdlp_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_pin_level,
    input  logic                                i_ack_press,
    input  logic                                i_ack_long,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_press_flag,
    input  logic                                i_long_flag,
    input  logic                                i_stable_pressed,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);

    localparam int unsigned CW = bdlp_pkg::COUNT_WIDTH_DEF;
    localparam int unsigned TW = bdlp_pkg::TICK_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = '1;

    bdlp_pkg::t_cfg    cfg;
    logic [2:0]        history;
    logic              stable_lvl;
    logic [CW-1:0]     hold_cnt;
    logic [CW-1:0]     timeout_cnt;
    logic              press_q;
    logic              long_q;
    bdlp_pkg::t_result due_flags[$];
    int                mismatches  = 0;
    int                outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    // count down, stopping at zero; true on the step that reaches zero
    function automatic logic tick_timeout();
        if (timeout_cnt == '0) begin
            return 1'b0;
        end
        timeout_cnt = timeout_cnt - 1'b1;
        return timeout_cnt == '0;
    endfunction

    task automatic debounce_tick(input logic pin, input logic ap, input logic al,
                                 output bdlp_pkg::t_result res);
        logic lvl;
        if (ap) press_q = 1'b0;
        if (al) long_q = 1'b0;
        history = {history[1:0], pin};
        if (history == 3'b000 || history == 3'b111) begin
            lvl = history[0];
            if (lvl != stable_lvl) begin
                stable_lvl = lvl;
                if (stable_lvl == cfg.pressed_level) begin
                    press_q     = 1'b1;
                    timeout_cnt = cfg.period_ticks[CW-1:0];
                end
            end else if (!cfg.repeat_mode) begin
                if (stable_lvl == cfg.pressed_level) begin
                    if (hold_cnt < cfg.long_ticks && hold_cnt != CNT_MAX) begin
                        hold_cnt = hold_cnt + 1'b1;
                    end else begin
                        press_q = 1'b0;
                        long_q  = 1'b1;
                    end
                end else if (tick_timeout()) begin
                    hold_cnt = '0;
                    press_q  = 1'b0;
                    long_q   = 1'b0;
                end
            end else if (tick_timeout()) begin
                if (stable_lvl == cfg.pressed_level) press_q = 1'b1;
                timeout_cnt = cfg.period_ticks[CW-1:0];
            end
        end
        res = '{press_flag: press_q, long_flag: long_q,
                stable_pressed: (stable_lvl == cfg.pressed_level)};
    endtask

    task automatic check_field(input string name, input logic exp_v, input logic act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0b, got %0b", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        bdlp_pkg::t_result res;
        if (!i_rst_n) begin
            cfg         = '{pressed_level: 1'b0, repeat_mode: 1'b0,
                            long_ticks: TW'(bdlp_pkg::RESET_LONG),
                            period_ticks: TW'(bdlp_pkg::RESET_PERIOD)};
            history     = 3'b111;
            stable_lvl  = 1'b1;
            hold_cnt    = '0;
            timeout_cnt = CW'(bdlp_pkg::RESET_TIMEOUT);
            press_q     = 1'b0;
            long_q      = 1'b0;
            due_flags.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bdlp_pkg::CFG_PRESSED_LEVEL: cfg.pressed_level = i_cfg_data[0];
                    bdlp_pkg::CFG_REPEAT_MODE:   cfg.repeat_mode   = i_cfg_data[0];
                    bdlp_pkg::CFG_LONG_TICKS: begin
                        cfg.long_ticks = i_cfg_data[TW-1:0];
                    end
                    bdlp_pkg::CFG_PERIOD_TICKS: begin
                        cfg.period_ticks = i_cfg_data[TW-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (due_flags.size() == 0) begin
                    $error("result transaction with nothing outstanding");
                    mismatches++;
                end else begin
                    res = due_flags.pop_front();
                    check_field("press_flag", res.press_flag, i_press_flag);
                    check_field("long_flag", res.long_flag, i_long_flag);
                    check_field("stable_pressed", res.stable_pressed, i_stable_pressed);
                end
            end
            if (i_in_valid && i_in_ready) begin
                debounce_tick(i_pin_level, i_ack_press, i_ack_long, res);
                due_flags.push_back(res);
            end
        end
        outstanding = due_flags.size();
    end

endmodule

@@ sim/tb_button_debounce_long_press.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press
// Drives pin ticks with random bounce, holds and acknowledges through several
// configurations, with random gaps on both channels and one long receiver
// stall. The checker instance predicts and compares the flags.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_OFF_CYCLES = 48;
    localparam int unsigned TW              = bdlp_pkg::TICK_WIDTH;
    localparam int unsigned DW              = bdlp_pkg::CFG_DATA_WIDTH;

    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               i_cfg_we     = 1'b0;
    logic [bdlp_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx    = bdlp_pkg::CFG_PRESSED_LEVEL;
    logic [DW-1:0]                      i_cfg_data   = '0;
    logic                               i_valid      = 1'b0;
    logic                               o_ready;
    logic                               i_pin_level  = 1'b0;
    logic                               i_ack_press  = 1'b0;
    logic                               i_ack_long   = 1'b0;
    logic                               o_valid;
    logic                               i_ready      = 1'b0;
    logic                               o_press_flag;
    logic                               o_long_flag;
    logic                               o_stable_pressed;

    int unsigned cycle_count   = 0;
    int          mismatches;
    int          outstanding;
    bit          idle_on       = 1'b1;
    bit          stall_request = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    button_debounce_long_press dut (.*);

    button_event_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_pin_level      (i_pin_level),
        .i_ack_press      (i_ack_press),
        .i_ack_long       (i_ack_long),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_press_flag     (o_press_flag),
        .i_long_flag      (o_long_flag),
        .i_stable_pressed (o_stable_pressed),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus the long hold-off once the sender is offering
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_request && i_valid) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                stall_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // called and returns at a falling edge
    task automatic offer_tick(input logic pin, input logic ap, input logic al);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pin_level <= pin;
        i_ack_press <= ap;
        i_ack_long  <= al;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic program_config(input logic plevel, input logic rmode,
                                  input logic [TW-1:0] long_t,
                                  input logic [TW-1:0] period_t);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bdlp_pkg::CFG_PRESSED_LEVEL;
        i_cfg_data <= DW'(plevel);
        @(negedge i_clk);
        i_cfg_idx  <= bdlp_pkg::CFG_REPEAT_MODE;
        i_cfg_data <= DW'(rmode);
        @(negedge i_clk);
        i_cfg_idx  <= bdlp_pkg::CFG_LONG_TICKS;
        i_cfg_data <= DW'(long_t);
        @(negedge i_clk);
        i_cfg_idx  <= bdlp_pkg::CFG_PERIOD_TICKS;
        i_cfg_data <= DW'(period_t);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly steady holds with the odd bounce, some pure noise
    task automatic run_phase(input logic plevel, input logic rmode,
                             input logic [TW-1:0] long_t,
                             input logic [TW-1:0] period_t, input int n);
        int   sent;
        int   len;
        int   cap;
        bit   noisy;
        logic level;
        logic pin;
        program_config(plevel, rmode, long_t, period_t);
        sent = 0;
        cap  = int'(long_t) + int'(period_t) + 6;
        if (cap > 40) cap = 40;
        while (sent < n) begin
            level = 1'($urandom_range(0, 1));
            noisy = ($urandom_range(0, 9) >= 7);
            len   = noisy ? $urandom_range(1, 8) : $urandom_range(1, cap);
            for (int k = 0; k < len; k++) begin
                if (noisy) pin = 1'($urandom_range(0, 1));
                else pin = ($urandom_range(0, 19) == 0) ? !level : level;
                offer_tick(pin, $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: released level high
        offer_tick(1'b1, 1'b0, 1'b0);
        offer_tick(1'b1, 1'b0, 1'b0);
        repeat (3) offer_tick(1'b0, 1'b0, 1'b0);
        offer_tick(1'b1, 1'b0, 1'b0);
        offer_tick(1'b0, 1'b0, 1'b0);
        offer_tick(1'b0, 1'b0, 1'b0);
        offer_tick(1'b0, 1'b0, 1'b0);
        offer_tick(1'b0, 1'b1, 1'b0);
        offer_tick(1'b0, 1'b0, 1'b1);
        offer_tick(1'b1, 1'b1, 1'b1);
        repeat (3) offer_tick(1'b1, 1'b0, 1'b0);

        // short thresholds: long press, then release timeout running to zero
        program_config(1'b0, 1'b0, 10'd2, 10'd2);
        repeat (7) offer_tick(1'b0, 1'b0, 1'b0);
        repeat (6) offer_tick(1'b1, 1'b0, 1'b0);

        run_phase(1'b1, 1'b0, 10'd8, 10'd6, 120);
        run_phase(1'b0, 1'b1, 10'd8, 10'd4, 120);
        run_phase(1'b1, 1'b1, 10'd0, 10'd1, 100);
        run_phase(1'b0, 1'b0, 10'd0, 10'd0, 100);
        run_phase(1'b0, 1'b0, 10'd1023, 10'd1023, 60);
        stall_request = 1'b1;
        repeat (4) begin
            run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      TW'($urandom_range(0, 24)), TW'($urandom_range(0, 24)), 100);
        end

        idle_on = 1'b0;
        run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  TW'($urandom_range(0, 12)), TW'($urandom_range(1, 12)), 130);

        drain_results();
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
